// File: rtl/rrbm_pkg.sv
// Shared types and constants for the ROM/RAM bank mapper.
package rrbm_pkg;

  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);
  localparam int unsigned RAM_OFS_W      = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_BANK_W     = 7;
  localparam int unsigned RAM_BANK_W     = 2;
  localparam int unsigned ADDR_W         = 16;
  localparam int unsigned DATA_W         = 8;
  localparam int unsigned PHYS_W         = 21;
  localparam int unsigned TARGET_W       = 3;
  localparam int unsigned CFG_DATA_W     = 7;
  localparam int unsigned CFG_INDEX_W    = 2;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [ROM_BANK_W-1:0] ROM_BANK_RESET = 7'd1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_MBC1 = 2'd1,
    KIND_MBC2 = 2'd2,
    KIND_MBC3 = 2'd3
  } mapper_kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAPPER_KIND   = 2'd0,
    CFG_ROM_BANK_MASK = 2'd1,
    CFG_RAM_PRESENT   = 2'd2,
    CFG_RAM_BANK_MASK = 2'd3
  } cfg_reg_t;

  typedef enum logic [TARGET_W-1:0] {
    T_ROM_READ     = 3'd0,
    T_RAM_READ     = 3'd1,
    T_RAM_WRITE    = 3'd2,
    T_RAM_BLOCKED  = 3'd3,
    T_REG_WRITE    = 3'd4,
    T_OUT_OF_RANGE = 3'd5
  } target_t;

  typedef struct packed {
    mapper_kind_t           mapper_kind;
    logic [ROM_BANK_W-1:0]  rom_bank_mask;
    logic                   ram_present;
    logic [RAM_BANK_W-1:0]  ram_bank_mask;
  } cfg_t;

  typedef struct packed {
    logic [ROM_BANK_W-1:0]  rom_bank;
    logic [RAM_BANK_W-1:0]  ram_bank;
    logic                   ram_enabled;
    logic                   ram_mode;
  } bank_state_t;

endpackage

// File: rtl/rrbm_in_if.sv
// Bus access channel: valid/ready with kind, address and value.
interface rrbm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [rrbm_pkg::ADDR_W-1:0] address;
  logic [rrbm_pkg::DATA_W-1:0] value;

  modport source (output valid, kind, address, value, input ready);
  modport sink   (input valid, kind, address, value, output ready);
endinterface

// File: rtl/rrbm_out_if.sv
// Result channel: valid/ready with target, physical address and write data.
interface rrbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrbm_pkg::TARGET_W-1:0] target;
  logic [rrbm_pkg::PHYS_W-1:0]   phys_address;
  logic [rrbm_pkg::DATA_W-1:0]   write_data;

  modport source (output valid, target, phys_address, write_data, input ready);
  modport sink   (input valid, target, phys_address, write_data, output ready);
endinterface

// File: rtl/rrbm_decode.sv
// Access decoder: result fields and next bank registers for one item.
module rrbm_decode (
  input  rrbm_pkg::cfg_t                 cfg,
  input  rrbm_pkg::bank_state_t          st,
  input  logic                           kind,
  input  logic [rrbm_pkg::ADDR_W-1:0]    address,
  input  logic [rrbm_pkg::DATA_W-1:0]    value,
  output rrbm_pkg::target_t              target,
  output logic [rrbm_pkg::PHYS_W-1:0]    phys_address,
  output logic [rrbm_pkg::DATA_W-1:0]    write_data,
  output rrbm_pkg::bank_state_t          st_nxt
);

  logic [4:0]                        lo_bank;
  logic [3:0]                        mbc2_bank;
  logic [rrbm_pkg::ROM_BANK_W-1:0]   rom_sel;
  logic [rrbm_pkg::RAM_BANK_W-1:0]   ram_sel;

  assign lo_bank   = (value[4:0] == 5'd0) ? 5'd1 : value[4:0];
  assign mbc2_bank = (value[3:0] == 4'd0) ? 4'd1 : value[3:0];
  assign rom_sel   = st.rom_bank & cfg.rom_bank_mask;
  assign ram_sel   = st.ram_bank & cfg.ram_bank_mask;

  always_comb begin
    st_nxt       = st;
    target       = rrbm_pkg::T_OUT_OF_RANGE;
    phys_address = '0;
    write_data   = '0;
    if (!address[15]) begin
      if (kind) begin
        target = rrbm_pkg::T_REG_WRITE;
        unique case (address[14:13])
          2'b00: begin
            if (cfg.mapper_kind != rrbm_pkg::KIND_MBC2 || !address[8]) begin
              st_nxt.ram_enabled = (value[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
            end
          end
          2'b01: begin
            if (cfg.mapper_kind == rrbm_pkg::KIND_MBC1) begin
              st_nxt.rom_bank = {st.rom_bank[6:5], lo_bank};
            end else if (cfg.mapper_kind == rrbm_pkg::KIND_MBC2) begin
              st_nxt.rom_bank = {3'd0, mbc2_bank};
            end
          end
          2'b10: begin
            if (cfg.mapper_kind == rrbm_pkg::KIND_MBC1) begin
              if (st.ram_mode) begin
                st_nxt.ram_bank = value[1:0];
              end else begin
                st_nxt.rom_bank = {value[1:0], st.rom_bank[4:0]};
              end
            end
          end
          default: begin
            if (cfg.mapper_kind == rrbm_pkg::KIND_MBC1) begin
              st_nxt.ram_mode = |value;
              if (|value) begin
                st_nxt.rom_bank = {2'd0, st.rom_bank[4:0]};
              end else begin
                st_nxt.ram_bank = '0;
              end
            end
          end
        endcase
      end else if (!address[14]) begin
        target       = rrbm_pkg::T_ROM_READ;
        phys_address = {{(rrbm_pkg::PHYS_W - rrbm_pkg::ROM_OFS_W){1'b0}},
                        address[rrbm_pkg::ROM_OFS_W-1:0]};
      end else begin
        target       = rrbm_pkg::T_ROM_READ;
        phys_address = {rom_sel, address[rrbm_pkg::ROM_OFS_W-1:0]};
      end
    end else if (address[15:13] == 3'b101) begin
      if (!st.ram_enabled || !cfg.ram_present) begin
        target = rrbm_pkg::T_RAM_BLOCKED;
      end else begin
        phys_address = {{(rrbm_pkg::PHYS_W - rrbm_pkg::RAM_OFS_W - rrbm_pkg::RAM_BANK_W){1'b0}},
                        ram_sel, address[rrbm_pkg::RAM_OFS_W-1:0]};
        if (kind) begin
          target     = rrbm_pkg::T_RAM_WRITE;
          write_data = value;
        end else begin
          target = rrbm_pkg::T_RAM_READ;
        end
      end
    end
  end

endmodule

// File: rtl/rom_ram_bank_mapper.sv
// Cartridge ROM/RAM bank mapper top level.
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   kind, address[15:0], value[7:0]
//  out_ch   out  valid/ready   target[2:0], phys_address[20:0], write_data[7:0]
//  cfg      in   cfg_we        cfg_index[1:0], cfg_data[6:0]
//
// One item per cycle while in_ch.ready is high; its result is registered at the accepting edge.
// The bank registers update at the accepting edge, so the next item sees them.
// A single output register holds the result; in_ch.ready drops only while that
// register is full and out_ch.ready is low.
// Reset (rst_n low, synchronous) sets rom_bank and rom_bank_mask to 1, the other
// bank and config fields and the output valid flag to 0.
module rom_ram_bank_mapper (
  input  logic                                clk,
  input  logic                                rst_n,
  rrbm_in_if.sink                             in_ch,
  rrbm_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [rrbm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rrbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rrbm_pkg::cfg_t                    cfg_r;
  rrbm_pkg::bank_state_t             st_r;
  rrbm_pkg::bank_state_t             st_nxt;
  rrbm_pkg::target_t                 target_nxt;
  logic [rrbm_pkg::PHYS_W-1:0]       phys_nxt;
  logic [rrbm_pkg::DATA_W-1:0]       data_nxt;
  logic                              out_valid_r;
  rrbm_pkg::target_t                 out_target_r;
  logic [rrbm_pkg::PHYS_W-1:0]       out_phys_r;
  logic [rrbm_pkg::DATA_W-1:0]       out_data_r;
  logic                              in_accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  rrbm_decode u_decode (
    .cfg          (cfg_r),
    .st           (st_r),
    .kind         (in_ch.kind),
    .address      (in_ch.address),
    .value        (in_ch.value),
    .target       (target_nxt),
    .phys_address (phys_nxt),
    .write_data   (data_nxt),
    .st_nxt       (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mapper_kind   <= rrbm_pkg::KIND_NONE;
      cfg_r.rom_bank_mask <= rrbm_pkg::ROM_BANK_RESET;
      cfg_r.ram_present   <= 1'b0;
      cfg_r.ram_bank_mask <= '0;
    end else if (cfg_we) begin
      unique case (rrbm_pkg::cfg_reg_t'(cfg_index))
        rrbm_pkg::CFG_MAPPER_KIND:
          cfg_r.mapper_kind <= rrbm_pkg::mapper_kind_t'(cfg_data[1:0]);
        rrbm_pkg::CFG_ROM_BANK_MASK:
          cfg_r.rom_bank_mask <= cfg_data[rrbm_pkg::ROM_BANK_W-1:0];
        rrbm_pkg::CFG_RAM_PRESENT:
          cfg_r.ram_present <= cfg_data[0];
        default:
          cfg_r.ram_bank_mask <= cfg_data[rrbm_pkg::RAM_BANK_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.rom_bank    <= rrbm_pkg::ROM_BANK_RESET;
      st_r.ram_bank    <= '0;
      st_r.ram_enabled <= 1'b0;
      st_r.ram_mode    <= 1'b0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_target_r <= target_nxt;
      out_phys_r   <= phys_nxt;
      out_data_r   <= data_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.target       = out_target_r;
  assign out_ch.phys_address = out_phys_r;
  assign out_ch.write_data   = out_data_r;

  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.rom_bank != '0)
    else $error("rom bank register reached zero");

  a_ram_bank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ram_bank != '0 |-> st_r.ram_mode)
    else $error("ram bank set outside ram mode");

  a_oor_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_ch.address[15:13] == 3'b100 || in_ch.address[15:14] == 2'b11)
    |=> $stable(st_r))
    else $error("out of range item changed bank state");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
